[sv/fipc_pkg.sv]
`default_nettype none

package fipc_pkg;

  // loop timing and fixed-point scale constants
  localparam int unsigned SAMPLE_PERIOD_MS = 1;
  localparam int unsigned RATE_SCALE       = 1000;  // ms to seconds for the error change
  localparam int unsigned AREA_DIVISOR     = 125;   // 2000 over the Q4.12 to Q16.16 step of 16
  localparam int unsigned UNIT_Q20         = 1 << 20;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PC_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_GAIN  = 3'd0,
    REG_CHANGE_GAIN = 3'd1,
    REG_OUTPUT_GAIN = 3'd2,
    REG_MIN_OUTPUT  = 3'd3,
    REG_MAX_OUTPUT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_OUT_BUSY
  } hold_e;

  typedef enum logic [1:0] {
    JUMP_NEXT,
    JUMP_ALWAYS,
    JUMP_RESTART
  } jump_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_EG,
    MUL_DIFF_K,
    MUL_PROD_CG,
    MUL_PROD_MP,
    MUL_RULE_OG,
    MUL_SUM_P,
    MUL_AREA_M
  } mul_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_DIFF,
    WB_FE,
    WB_SAT,
    WB_FCE,
    WB_RULE,
    WB_RULE_OUT,
    WB_PREV_RULE,
    WB_AREA,
    WB_ACC,
    WB_CLEAR
  } wb_e;

  typedef struct packed {
    logic            take;
    hold_e           hold;
    mul_e            mul;
    wb_e             wb;
    jump_e           jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  // program addresses
  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH  = 4'd1;
  localparam logic [PC_W-1:0] STEP_FE        = 4'd2;
  localparam logic [PC_W-1:0] STEP_CHANGE    = 4'd3;
  localparam logic [PC_W-1:0] STEP_SAT       = 4'd4;
  localparam logic [PC_W-1:0] STEP_FCE       = 4'd5;
  localparam logic [PC_W-1:0] STEP_RULE      = 4'd6;
  localparam logic [PC_W-1:0] STEP_RULE_GAIN = 4'd7;
  localparam logic [PC_W-1:0] STEP_RULE_OUT  = 4'd8;
  localparam logic [PC_W-1:0] STEP_SUM       = 4'd9;
  localparam logic [PC_W-1:0] STEP_AREA_DIV  = 4'd10;
  localparam logic [PC_W-1:0] STEP_AREA      = 4'd11;
  localparam logic [PC_W-1:0] STEP_ACC       = 4'd12;
  localparam logic [PC_W-1:0] STEP_RESTART   = 4'd13;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{take: 1'b0, hold: HOLD_NONE, mul: MUL_NONE, wb: WB_NONE,
          jump: JUMP_NEXT, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: begin
        w.take = 1'b1;
        w.hold = HOLD_NO_INPUT;
      end
      STEP_DISPATCH: begin
        w.mul    = MUL_ERR_EG;
        w.wb     = WB_DIFF;
        w.jump   = JUMP_RESTART;
        w.target = STEP_RESTART;
      end
      STEP_FE: begin
        w.mul = MUL_DIFF_K;
        w.wb  = WB_FE;
      end
      STEP_CHANGE:    w.mul = MUL_PROD_CG;
      STEP_SAT: begin
        w.mul = MUL_PROD_MP;
        w.wb  = WB_SAT;
      end
      STEP_FCE:       w.wb  = WB_FCE;
      STEP_RULE:      w.wb  = WB_RULE;
      STEP_RULE_GAIN: w.mul = MUL_RULE_OG;
      STEP_RULE_OUT:  w.wb  = WB_RULE_OUT;
      STEP_SUM: begin
        w.mul = MUL_SUM_P;
        w.wb  = WB_PREV_RULE;
      end
      STEP_AREA_DIV:  w.mul = MUL_AREA_M;
      STEP_AREA:      w.wb  = WB_AREA;
      STEP_ACC: begin
        w.hold   = HOLD_OUT_BUSY;
        w.wb     = WB_ACC;
        w.jump   = JUMP_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_RESTART: begin
        w.hold   = HOLD_OUT_BUSY;
        w.wb     = WB_CLEAR;
        w.jump   = JUMP_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jump   = JUMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/fuzzy_incremental_pi_controller_core.sv]
// channel | direction | handshake                   | payload
// cfg     | in        | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i / in_ready_o     | setpoint_i, feedback_i, restart_i
// out     | out       | out_valid_o / out_ready_i   | drive_out_o
//
// a normal word runs from the dispatch step through the term, rule, sum and area steps to the
// accumulate step, which writes the result register; a restart word jumps from dispatch to the
// restart step, which clears the loop; the multiplying steps share a single 31x32 multiplier
// reset: rst_ni clears the step counter, the loop state and the result flag, and presets the gains
// a new word is taken once the program is back at its idle step, even while the
// previous result still waits; the final step holds only if that result is untaken
// cfg writes are always ready and take effect at the next edge
`default_nettype none

module fuzzy_incremental_pi_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fipc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [15:0]                 setpoint_i,
  input  logic signed [15:0]                 feedback_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [15:0]                 drive_out_o
);

  // shared multiplier geometry
  localparam int unsigned MulAW = 31;
  localparam int unsigned MulBW = 32;
  localparam int unsigned ProdW = MulAW + MulBW;

  // reciprocal constants: floor(u / d) == (u * ceil(2^s / d)) >> s for u < 2^31
  localparam int unsigned ShiftP    = MulAW + $clog2(fipc_pkg::SAMPLE_PERIOD_MS);
  localparam int unsigned ShiftArea = MulAW + $clog2(fipc_pkg::AREA_DIVISOR);
  localparam logic [63:0] RecipPFull =
      ((64'd1 << ShiftP) + 64'(fipc_pkg::SAMPLE_PERIOD_MS) - 64'd1) /
      64'(fipc_pkg::SAMPLE_PERIOD_MS);
  localparam logic [63:0] RecipAreaFull =
      ((64'd1 << ShiftArea) + 64'(fipc_pkg::AREA_DIVISOR) - 64'd1) /
      64'(fipc_pkg::AREA_DIVISOR);
  localparam logic [MulBW-1:0] RecipP    = RecipPFull[MulBW-1:0];
  localparam logic [MulBW-1:0] RecipArea = RecipAreaFull[MulBW-1:0];

  // change products at or above this give a quotient beyond one, so they saturate
  localparam logic [ProdW-1:0] FceLimit =
      ProdW'(64'(fipc_pkg::UNIT_Q20 + 1) * 64'(fipc_pkg::SAMPLE_PERIOD_MS));

  // sequencer
  logic [fipc_pkg::PC_W-1:0] pc_q, pc_d;
  fipc_pkg::ucode_t           ctl;
  logic                       in_acc, out_free, stall, go;

  // configuration
  logic [15:0]        eg_q, cg_q, og_q;
  logic signed [15:0] min_q, max_q;

  // loop state
  logic signed [16:0] prev_err_q;
  logic signed [21:0] prev_rule_q;
  logic signed [19:0] acc_q;

  // datapath registers
  logic signed [16:0] err_q;
  logic               restart_q;
  logic signed [17:0] diff_q;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic               neg_q, neg_d;
  logic               sat_q;
  logic signed [13:0] fe_q, fce_q, rule_q;
  logic signed [21:0] rule_out_q;
  logic signed [31:0] area_q;
  logic               out_valid_q;
  logic signed [15:0] drive_q;

  // operand shaping
  logic [16:0]        err_mag;
  logic [17:0]        diff_mag;
  logic [13:0]        rule_mag;
  logic signed [22:0] sum_w;
  logic [22:0]        sum_mag;
  logic [MulAW-1:0]   area_u;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;

  // result shaping
  logic [ProdW-1:0]   quo_p, quo_a;
  logic [20:0]        fe_mag, fce_mag, q20_mag;
  logic signed [21:0] q20_full;
  logic signed [14:0] rule_sum;
  logic signed [29:0] ro_full;
  logic [30:0]        area_mag;
  logic signed [31:0] area_full;
  logic signed [19:0] lo_w, hi_w, acc_new;
  logic signed [32:0] acc_sum;

  // ---------------------------------------------------------------- control
  assign ctl         = fipc_pkg::ucode_rom(pc_q);
  assign in_ready_o  = ctl.take;
  assign in_acc      = in_valid_i & ctl.take;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign stall       = ((ctl.hold == fipc_pkg::HOLD_NO_INPUT) && !in_valid_i) ||
                       ((ctl.hold == fipc_pkg::HOLD_OUT_BUSY) && !out_free);
  assign go          = ~stall;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign drive_out_o = drive_q;

  always_comb begin
    pc_d = pc_q;
    if (go) begin
      unique case (ctl.jump)
        fipc_pkg::JUMP_NEXT:    pc_d = pc_q + 1'b1;
        fipc_pkg::JUMP_ALWAYS:  pc_d = ctl.target;
        fipc_pkg::JUMP_RESTART: pc_d = restart_q ? ctl.target : pc_q + 1'b1;
        default:                pc_d = fipc_pkg::STEP_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------- operands
  assign err_mag  = err_q[16] ? 17'(-err_q) : 17'(err_q);
  assign diff_mag = diff_q[17] ? 18'(-diff_q) : 18'(diff_q);
  assign rule_mag = rule_q[13] ? 14'(-rule_q) : 14'(rule_q);
  assign sum_w    = 23'(rule_out_q) + 23'(prev_rule_q);
  assign sum_mag  = sum_w[22] ? 23'(-sum_w) : 23'(sum_w);
  // floor of a negative area uses the ceiling of the magnitude
  assign area_u   = neg_q ? prod_q[MulAW-1:0] + MulAW'(fipc_pkg::AREA_DIVISOR - 1)
                          : prod_q[MulAW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg_d = neg_q;
    case (ctl.mul)
      fipc_pkg::MUL_ERR_EG: begin
        mul_a = MulAW'(err_mag);
        mul_b = MulBW'(eg_q);
        neg_d = err_q[16];
      end
      fipc_pkg::MUL_DIFF_K: begin
        mul_a = MulAW'(diff_mag);
        mul_b = MulBW'(fipc_pkg::RATE_SCALE);
        neg_d = diff_q[17];
      end
      fipc_pkg::MUL_PROD_CG: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = MulBW'(cg_q);
      end
      fipc_pkg::MUL_PROD_MP: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = RecipP;
      end
      fipc_pkg::MUL_RULE_OG: begin
        mul_a = MulAW'(rule_mag);
        mul_b = MulBW'(og_q);
        neg_d = rule_q[13];
      end
      fipc_pkg::MUL_SUM_P: begin
        mul_a = MulAW'(sum_mag);
        mul_b = MulBW'(fipc_pkg::SAMPLE_PERIOD_MS);
        neg_d = sum_w[22];
      end
      fipc_pkg::MUL_AREA_M: begin
        mul_a = area_u;
        mul_b = RecipArea;
      end
      default: ;
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // ---------------------------------------------------------------- results
  // error and change terms saturate at one in Q.20, then floor to Q2.12
  assign quo_p   = prod_q >> ShiftP;
  assign fe_mag  = (prod_q > ProdW'(fipc_pkg::UNIT_Q20)) ? 21'(fipc_pkg::UNIT_Q20)
                                                          : prod_q[20:0];
  assign fce_mag = sat_q ? 21'(fipc_pkg::UNIT_Q20) : quo_p[20:0];
  assign q20_mag = (ctl.wb == fipc_pkg::WB_FE) ? fe_mag : fce_mag;
  assign q20_full = neg_q ? -$signed({1'b0, q20_mag}) : $signed({1'b0, q20_mag});

  assign rule_sum = 15'(fe_q) + 15'(fce_q);
  assign ro_full  = neg_q ? -$signed({1'b0, prod_q[28:0]}) : $signed({1'b0, prod_q[28:0]});

  assign quo_a     = prod_q >> ShiftArea;
  assign area_mag  = quo_a[30:0];
  assign area_full = neg_q ? -$signed({1'b0, area_mag}) : $signed({1'b0, area_mag});

  // clamp: lower bound wins the first test
  assign lo_w    = {min_q, 4'b0000};
  assign hi_w    = {max_q, 4'b0000};
  assign acc_sum = 33'(acc_q) + 33'(area_q);

  always_comb begin
    if (acc_sum < 33'(lo_w)) begin
      acc_new = lo_w;
    end else if (acc_sum > 33'(hi_w)) begin
      acc_new = hi_w;
    end else begin
      acc_new = acc_sum[19:0];
    end
  end

  // ----------------------------------------------------- sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= fipc_pkg::STEP_IDLE;
      out_valid_q <= 1'b0;
      prev_err_q  <= '0;
      prev_rule_q <= '0;
      acc_q       <= '0;
    end else begin
      pc_q <= pc_d;
      if (go && (ctl.wb == fipc_pkg::WB_ACC || ctl.wb == fipc_pkg::WB_CLEAR)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (go) begin
        case (ctl.wb)
          fipc_pkg::WB_DIFF:      prev_err_q  <= err_q;
          fipc_pkg::WB_PREV_RULE: prev_rule_q <= rule_out_q;
          fipc_pkg::WB_ACC:       acc_q       <= acc_new;
          fipc_pkg::WB_CLEAR: begin
            prev_err_q  <= '0;
            prev_rule_q <= '0;
            acc_q       <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eg_q  <= 16'd256;
      cg_q  <= 16'd256;
      og_q  <= 16'd256;
      min_q <= 16'sd0;
      max_q <= 16'sd32767;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fipc_pkg::REG_ERROR_GAIN:  eg_q  <= cfg_data_i;
        fipc_pkg::REG_CHANGE_GAIN: cg_q  <= cfg_data_i;
        fipc_pkg::REG_OUTPUT_GAIN: og_q  <= cfg_data_i;
        fipc_pkg::REG_MIN_OUTPUT:  min_q <= cfg_data_i;
        fipc_pkg::REG_MAX_OUTPUT:  max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q     <= 17'(setpoint_i) - 17'(feedback_i);
      restart_q <= restart_i;
    end
    if (go && ctl.mul != fipc_pkg::MUL_NONE) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
    end
    if (go) begin
      case (ctl.wb)
        fipc_pkg::WB_DIFF:     diff_q     <= 18'(err_q) - 18'(prev_err_q);
        fipc_pkg::WB_FE:       fe_q       <= q20_full[21:8];
        fipc_pkg::WB_SAT:      sat_q      <= (prod_q >= FceLimit);
        fipc_pkg::WB_FCE:      fce_q      <= q20_full[21:8];
        fipc_pkg::WB_RULE:     rule_q     <= rule_sum[14:1];
        fipc_pkg::WB_RULE_OUT: rule_out_q <= ro_full[29:8];
        fipc_pkg::WB_AREA:     area_q     <= area_full;
        fipc_pkg::WB_ACC:      drive_q    <= acc_new[19:4];
        fipc_pkg::WB_CLEAR:    drive_q    <= '0;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- assertions
  // an accepted word keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in consecutive cycles");

  // saturated change term stays within plus or minus one
  a_fce_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && ctl.wb == fipc_pkg::WB_FCE |=> fce_q <= 14'sd4096 && fce_q >= -14'sd4096)
    else $error("change term outside unit range");

  // accumulator lands inside an ordered clamp window
  a_acc_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && ctl.wb == fipc_pkg::WB_ACC && min_q <= max_q |=> acc_q >= lo_w && acc_q <= hi_w)
    else $error("accumulator outside clamp window");

  // restart leaves an empty loop and a zero word
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && ctl.wb == fipc_pkg::WB_CLEAR |=> acc_q == '0 && drive_q == '0 && out_valid_q)
    else $error("restart did not clear the loop");

endmodule

`default_nettype wire
